// File: src/rlwq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlwq_pkg: shared types and constants of the recursive lock
// Sizes of the wait queue, requester IDs and hold count, request and status
// codes, and the control word that steers one wait-queue cell.
// ----------------------------------------------------------------------------
package rlwq_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int NUM_REQUESTERS = 64;
  localparam int COUNT_BITS     = 16;

  localparam int ACTION_W = 2;
  localparam int ID_W     = $clog2(NUM_REQUESTERS);
  localparam int WCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int STATUS_W = 4;

  // Request codes; any code with the unlock bit set acts as unlock
  localparam logic [ACTION_W-1:0] ACT_LOCK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TRYLOCK = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_UNLOCK  = 2'd2;
  localparam int                  ACT_UNLOCK_BIT = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACQUIRED       = 4'd0,
    ST_RECURSIVE      = 4'd1,
    ST_QUEUED         = 4'd2,
    ST_ALREADY_QUEUED = 4'd3,
    ST_QUEUE_FULL     = 4'd4,
    ST_TRY_BUSY       = 4'd5,
    ST_PARTIAL        = 4'd6,
    ST_RELEASED       = 4'd7,
    ST_NOT_OWNER      = 4'd8,
    ST_COUNT_FULL     = 4'd9
  } status_t;

  // Per-cell control word
  typedef struct packed {
    logic occupied;  // cell lies below the fill count
    logic tail;      // cell is the first free slot
    logic push;      // append the target ID at the tail
    logic pop;       // every cell takes its neighbor's ID
    logic remove;    // cells at and behind the matching one take their neighbor's ID
  } cell_ctl_t;

endpackage

// File: src/rlwq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlwq_cell: one slot of the shifting wait queue
// Holds one waiter ID, compares it against the request ID and moves toward
// the head when the queue pops or a waiter ahead of or in it is removed.
// ----------------------------------------------------------------------------
module rlwq_cell (
  input  logic                     clk,
  input  rlwq_pkg::cell_ctl_t      ctl,
  input  logic [rlwq_pkg::ID_W-1:0] target_id,
  input  logic [rlwq_pkg::ID_W-1:0] next_id,
  input  logic                     chain_in,
  output logic                     chain_out,
  output logic                     hit,
  output logic [rlwq_pkg::ID_W-1:0] id_out
);

  logic [rlwq_pkg::ID_W-1:0] id_r;
  logic [rlwq_pkg::ID_W-1:0] id_nxt;
  logic                      shift;

  // Match only live entries; pass the removal front down the row
  assign hit       = ctl.occupied && (id_r == target_id);
  assign chain_out = chain_in | hit;
  assign shift     = ctl.pop | (ctl.remove & chain_out);
  assign id_out    = id_r;

  // Advance from the neighbor, load at the tail, or hold
  always_comb begin
    id_nxt = id_r;
    if (shift) begin
      id_nxt = next_id;
    end else if (ctl.push && ctl.tail) begin
      id_nxt = target_id;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

endmodule

// File: src/recursive_lock_with_wait_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recursive_lock_with_wait_queue: recursive lock with a FIFO of waiters
// Lock, trylock and unlock requests update owner, hold count and a shifting
// row of queue cells; each request yields one result word.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; busy then stays
// high while the wait-queue cells compare the requester against every waiter
// and the lock state is updated, and in the next cycle out_valid is high for
// exactly one cycle with the result word. The receiver cannot stall, so the
// result must be captured in that cycle; a new request may be issued in that
// same cycle. Queue removal and pop both complete in the update state, since
// every cell shifts from its neighbor at once. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module recursive_lock_with_wait_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rlwq_pkg::ACTION_W-1:0]     in_action,
  input  logic [rlwq_pkg::ID_W-1:0]         in_requester_id,
  output logic                              out_valid,
  output logic                              out_granted,
  output logic [rlwq_pkg::STATUS_W-1:0]     out_status,
  output logic [rlwq_pkg::COUNT_BITS-1:0]   out_hold_count_out,
  output logic                              out_wake_valid,
  output logic [rlwq_pkg::ID_W-1:0]         out_wake_id,
  output logic [rlwq_pkg::WCNT_W-1:0]       out_waiting_count
);

  localparam int QD   = rlwq_pkg::QUEUE_DEPTH;
  localparam int IDW  = rlwq_pkg::ID_W;
  localparam int CW   = rlwq_pkg::WCNT_W;
  localparam int HCW  = rlwq_pkg::COUNT_BITS;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                          state_r;
  logic [rlwq_pkg::ACTION_W-1:0]   action_r;
  logic [IDW-1:0]                  req_id_r;
  logic                            lock_held_r, lock_held_nxt;
  logic [IDW-1:0]                  owner_r, owner_nxt;
  logic [HCW-1:0]                  hold_r, hold_nxt;
  logic [CW-1:0]                   count_r, count_nxt;

  logic                            out_valid_r;
  logic                            granted_r, granted_nxt;
  rlwq_pkg::status_t               status_r, status_nxt;
  logic                            wake_valid_r, wake_valid_nxt;
  logic [IDW-1:0]                  wake_id_r, wake_id_nxt;

  logic                            do_pop, do_remove, do_push;
  logic                            is_owner, queued, accept;

  logic [IDW-1:0]                  cell_id [QD];
  logic [QD-1:0]                   cell_hit;
  logic [QD:0]                     chain;
  rlwq_pkg::cell_ctl_t             cell_ctl [QD];

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Row of queue cells, head at index zero
  assign chain[0] = 1'b0;
  for (genvar i = 0; i < QD; i++) begin : g_cell
    logic [IDW-1:0] next_id;
    if (i == QD - 1) begin : g_last
      assign next_id = '0;
    end else begin : g_mid
      assign next_id = cell_id[i+1];
    end

    assign cell_ctl[i].occupied = (CW'(i) < count_r);
    assign cell_ctl[i].tail     = (CW'(i) == count_r);
    assign cell_ctl[i].push     = do_push;
    assign cell_ctl[i].pop      = do_pop;
    assign cell_ctl[i].remove   = do_remove;

    rlwq_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .target_id (req_id_r),
      .next_id   (next_id),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .hit       (cell_hit[i]),
      .id_out    (cell_id[i])
    );
  end

  assign is_owner = lock_held_r && (owner_r == req_id_r);
  assign queued   = |cell_hit;

  // Decide the request against the current lock and queue state
  always_comb begin
    lock_held_nxt  = lock_held_r;
    owner_nxt      = owner_r;
    hold_nxt       = hold_r;
    count_nxt      = count_r;
    granted_nxt    = 1'b0;
    status_nxt     = rlwq_pkg::ST_ACQUIRED;
    wake_valid_nxt = 1'b0;
    wake_id_nxt    = '0;
    do_pop         = 1'b0;
    do_remove      = 1'b0;
    do_push        = 1'b0;

    if (state_r == S_EXEC) begin
      if (action_r[rlwq_pkg::ACT_UNLOCK_BIT]) begin
        if (!is_owner) begin
          status_nxt = rlwq_pkg::ST_NOT_OWNER;
        end else if (hold_r > HCW'(1)) begin
          hold_nxt    = hold_r - HCW'(1);
          granted_nxt = 1'b1;
          status_nxt  = rlwq_pkg::ST_PARTIAL;
        end else begin
          lock_held_nxt = 1'b0;
          owner_nxt     = '0;
          hold_nxt      = '0;
          status_nxt    = rlwq_pkg::ST_RELEASED;
          if (count_r != '0) begin
            wake_valid_nxt = 1'b1;
            wake_id_nxt    = cell_id[0];
            do_pop         = 1'b1;
            count_nxt      = count_r - CW'(1);
          end
        end
      end else if (is_owner) begin
        if (hold_r == '1) begin
          status_nxt = rlwq_pkg::ST_COUNT_FULL;
        end else begin
          hold_nxt    = hold_r + HCW'(1);
          granted_nxt = 1'b1;
          status_nxt  = rlwq_pkg::ST_RECURSIVE;
          if (queued) begin
            do_remove = 1'b1;
            count_nxt = count_r - CW'(1);
          end
        end
      end else if (!lock_held_r) begin
        lock_held_nxt = 1'b1;
        owner_nxt     = req_id_r;
        hold_nxt      = HCW'(1);
        granted_nxt   = 1'b1;
        status_nxt    = rlwq_pkg::ST_ACQUIRED;
        if (queued) begin
          do_remove = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end else if (action_r == rlwq_pkg::ACT_TRYLOCK) begin
        status_nxt = rlwq_pkg::ST_TRY_BUSY;
      end else if (queued) begin
        status_nxt = rlwq_pkg::ST_ALREADY_QUEUED;
      end else if (count_r >= CW'(QD)) begin
        status_nxt = rlwq_pkg::ST_QUEUE_FULL;
      end else begin
        do_push    = 1'b1;
        count_nxt  = count_r + CW'(1);
        status_nxt = rlwq_pkg::ST_QUEUED;
      end
    end
  end

  // Hold state, lock registers and the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lock_held_r <= 1'b0;
      owner_r     <= '0;
      hold_r      <= '0;
      count_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            action_r <= in_action;
            req_id_r <= in_requester_id;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          lock_held_r  <= lock_held_nxt;
          owner_r      <= owner_nxt;
          hold_r       <= hold_nxt;
          count_r      <= count_nxt;
          granted_r    <= granted_nxt;
          status_r     <= status_nxt;
          wake_valid_r <= wake_valid_nxt;
          wake_id_r    <= wake_id_nxt;
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted        = granted_r;
  assign out_status         = status_r;
  assign out_hold_count_out = hold_r;
  assign out_wake_valid     = wake_valid_r;
  assign out_wake_id        = wake_id_r;
  assign out_waiting_count  = count_r;

  // Every accepted word is followed by its result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("result strobe missing after accepted word");

  // A grant leaves the lock held with a nonzero count
  a_grant_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> lock_held_r && (hold_r != '0))
    else $error("grant reported on a free lock");

  // A wake only comes with a released lock
  a_wake_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake_valid |-> !lock_held_r && (hold_r == '0))
    else $error("waiter woken while lock still held");

  // Fill count never passes the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QD))
    else $error("wait queue overfilled");

endmodule
